### rtl/tfm_pkg.sv
// ----------------------------------------------------------------------------
// tfm_pkg: shared types and constants of the timing fork monitor
// Field widths, edge and level codes, violation codes and register indexes.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int unsigned TIME_W     = 32;  // width of the time stamp arithmetic
  localparam int unsigned NOW_W      = 32;  // width of the now_time field
  localparam int unsigned NODE_W     = 16;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned EDGE_W     = 2;
  localparam int unsigned MARGIN_W   = 16;
  localparam int unsigned VIOL_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_LOW     = 2'd0,
    LVL_HIGH    = 2'd1,
    LVL_UNKNOWN = 2'd2,
    LVL_INVALID = 2'd3
  } level_e;

  typedef enum logic [EDGE_W-1:0] {
    EDGE_BOTH  = 2'd0,
    EDGE_RISE  = 2'd1,
    EDGE_FALL  = 2'd2,
    EDGE_ANY   = 2'd3
  } edge_e;

  typedef enum logic [VIOL_W-1:0] {
    VIOL_NONE   = 2'd0,
    VIOL_ORDER  = 2'd1,
    VIOL_MARGIN = 2'd2
  } viol_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT_NODE    = 3'd0,
    REG_FIRST_NODE   = 3'd1,
    REG_SECOND_NODE  = 3'd2,
    REG_ROOT_EDGES   = 3'd3,
    REG_FIRST_EDGES  = 3'd4,
    REG_SECOND_EDGES = 3'd5,
    REG_MARGIN       = 3'd6
  } cfg_reg_e;

  // A high level qualifies unless only falling edges count, a low level unless
  // only rising edges count; an unknown level never qualifies.
  function automatic logic edge_qualifies(logic [EDGE_W-1:0] code,
                                          logic [LEVEL_W-1:0] level);
    logic q;
    q = 1'b0;
    if (level == LVL_HIGH) begin
      q = (code != EDGE_FALL);
    end else if (level == LVL_LOW) begin
      q = (code != EDGE_RISE);
    end
    return q;
  endfunction

endpackage

### rtl/tfm_ifs.sv
// ----------------------------------------------------------------------------
// tfm_ifs: channel interfaces of the timing fork monitor
// Event input, result output and register write channels.
// ----------------------------------------------------------------------------
interface tfm_evt_if;
  logic                          valid;
  logic                          ready;
  logic [tfm_pkg::NODE_W-1:0]    node_id;
  logic [tfm_pkg::LEVEL_W-1:0]   new_value;
  logic [tfm_pkg::NOW_W-1:0]     now_time;
  logic                          in_reset;

  modport source (output valid, node_id, new_value, now_time, in_reset, input ready);
  modport sink   (input valid, node_id, new_value, now_time, in_reset, output ready);
endinterface

interface tfm_res_if;
  logic                          valid;
  logic                          ready;
  logic [tfm_pkg::VIOL_W-1:0]    violation;

  modport source (output valid, violation, input ready);
  modport sink   (input valid, violation, output ready);
endinterface

interface tfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tfm_pkg::CFG_IDX_W-1:0]   index;
  logic [tfm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/timing_fork_monitor.sv
// ----------------------------------------------------------------------------
// timing_fork_monitor: order and margin checker for one timing fork
// Watches root -> (first before second) over a stream of signal changes.
// ----------------------------------------------------------------------------
// One signal change is taken per clock while the output is not stalled and gives
// exactly one result. An event is held in the input register, where three id
// compares and one TIME_W+1 bit add/compare against the stored stamp update the
// fork phase; the result register follows the input register. The phase loop
// closes through the phase register, so back-to-back events see each other's
// effect. Register writes are always accepted and take effect on the next
// cycle; write them only while no event is in flight.
module timing_fork_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  tfm_evt_if.sink   evt_i,
  tfm_res_if.source res_o,
  tfm_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_ARMED    = 2'd1,
    PH_PENDING  = 2'd2,
    PH_TIMING   = 2'd3
  } phase_e;

  // configuration
  logic [tfm_pkg::NODE_W-1:0]   root_node_q, first_node_q, second_node_q;
  logic [tfm_pkg::EDGE_W-1:0]   root_edges_q, first_edges_q, second_edges_q;
  logic [tfm_pkg::MARGIN_W-1:0] margin_q;

  // input register
  logic                         in_valid_q;
  logic [tfm_pkg::NODE_W-1:0]   node_q;
  logic [tfm_pkg::LEVEL_W-1:0]  level_q;
  logic [tfm_pkg::TIME_W-1:0]   now_q;
  logic                         rst_flag_q;

  // fork state
  phase_e                       phase_q, phase_d;
  logic [tfm_pkg::TIME_W-1:0]   stamp_q, stamp_d;

  // result register
  logic                         out_valid_q;
  logic [tfm_pkg::VIOL_W-1:0]   viol_q, viol_d;

  logic out_free;
  logic advance;
  logic evt_xfer;
  logic [tfm_pkg::TIME_W:0] limit;

  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = in_valid_q && out_free;
  assign evt_xfer = evt_i.valid && evt_i.ready;

  assign evt_i.ready     = !in_valid_q || out_free;
  assign cfg_i.ready     = 1'b1;
  assign res_o.valid     = out_valid_q;
  assign res_o.violation = viol_q;

  // Root, then first, then second, each seeing the phase the previous left.
  always_comb begin
    phase_d = phase_q;
    stamp_d = stamp_q;
    viol_d  = tfm_pkg::VIOL_NONE;
    limit   = '0;
    if (!rst_flag_q) begin
      if (node_q == root_node_q) begin
        phase_d = tfm_pkg::edge_qualifies(root_edges_q, level_q) ? PH_ARMED : PH_INACTIVE;
      end
      if (node_q == first_node_q && phase_d != PH_INACTIVE &&
          tfm_pkg::edge_qualifies(first_edges_q, level_q)) begin
        case (phase_d)
          PH_PENDING: begin
            viol_d  = tfm_pkg::VIOL_ORDER;
            phase_d = PH_INACTIVE;
          end
          PH_ARMED: begin
            if (margin_q != '0) begin
              stamp_d = now_q;
              phase_d = PH_TIMING;
            end
          end
          PH_TIMING: begin
            stamp_d = now_q;
          end
          default: begin
            phase_d = PH_INACTIVE;
          end
        endcase
      end
      // without wrap: stamp + margin > now
      limit = {1'b0, stamp_d} + (tfm_pkg::TIME_W + 1)'(margin_q);
      if (node_q == second_node_q && phase_d != PH_INACTIVE &&
          tfm_pkg::edge_qualifies(second_edges_q, level_q)) begin
        if (phase_d == PH_TIMING) begin
          if (limit > {1'b0, now_q}) begin
            viol_d  = tfm_pkg::VIOL_MARGIN;
            phase_d = PH_INACTIVE;
          end
        end else begin
          phase_d = PH_PENDING;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_node_q    <= '0;
      first_node_q   <= '0;
      second_node_q  <= '0;
      root_edges_q   <= '0;
      first_edges_q  <= '0;
      second_edges_q <= '0;
      margin_q       <= '0;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      phase_q        <= PH_INACTIVE;
      stamp_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          tfm_pkg::REG_ROOT_NODE:    root_node_q    <= cfg_i.data;
          tfm_pkg::REG_FIRST_NODE:   first_node_q   <= cfg_i.data;
          tfm_pkg::REG_SECOND_NODE:  second_node_q  <= cfg_i.data;
          tfm_pkg::REG_ROOT_EDGES:   root_edges_q   <= cfg_i.data[tfm_pkg::EDGE_W-1:0];
          tfm_pkg::REG_FIRST_EDGES:  first_edges_q  <= cfg_i.data[tfm_pkg::EDGE_W-1:0];
          tfm_pkg::REG_SECOND_EDGES: second_edges_q <= cfg_i.data[tfm_pkg::EDGE_W-1:0];
          tfm_pkg::REG_MARGIN:       margin_q       <= cfg_i.data;
          default: ;
        endcase
      end
      // input stage
      if (evt_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      // fork state and result stage
      if (advance) begin
        phase_q     <= phase_d;
        stamp_q     <= stamp_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (evt_xfer) begin
      node_q     <= evt_i.node_id;
      level_q    <= evt_i.new_value;
      now_q      <= tfm_pkg::TIME_W'(evt_i.now_time);
      rst_flag_q <= evt_i.in_reset;
    end
    if (advance) begin
      viol_q <= viol_d;
    end
  end

endmodule

### rtl/tfm_checker.sv
// ----------------------------------------------------------------------------
// tfm_checker: port-level checks of the timing fork monitor
// Watches the event and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module tfm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         evt_valid_i,
  input logic                         evt_ready_i,
  input logic                         evt_in_reset_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic [tfm_pkg::VIOL_W-1:0]   res_violation_i
);

  logic evt_xfer;
  assign evt_xfer = evt_valid_i && evt_ready_i;

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_violation_i))
    else $error("stalled result changed or dropped");

  a_viol_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_violation_i == tfm_pkg::VIOL_NONE ||
                     res_violation_i == tfm_pkg::VIOL_ORDER ||
                     res_violation_i == tfm_pkg::VIOL_MARGIN))
    else $error("undefined violation code");

  // an idle output fills only after an event transfer has passed the input register
  a_res_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(evt_xfer, 2))
    else $error("result without a matching event transfer");

  // an event flagged as in reset never reports a violation
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) && $past(evt_xfer && evt_in_reset_i, 2)
      |-> res_violation_i == tfm_pkg::VIOL_NONE)
    else $error("violation reported for an event during reset");

endmodule

bind timing_fork_monitor tfm_checker u_tfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .evt_valid_i     (evt_i.valid),
  .evt_ready_i     (evt_i.ready),
  .evt_in_reset_i  (evt_i.in_reset),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_violation_i (res_o.violation)
);
